// ----- rtl/bba_pkg.sv -----
// Shared types, constants and command structures of the bitmap block allocator.
package bba_pkg;

    localparam int IDX_W           = 10;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 11;
    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 1;
    localparam int DEF_MAX_BLOCKS  = 1024;
    localparam int DEF_BUCKET_BITS = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET      = COUNT_W'(1024);
    localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT = PADDR_W'(0);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic    scan_start;
        logic    scan_en;
        logic    sweep_start;
        logic    sweep_en;
        logic    commit;
        logic    emit;
        logic    grant;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic limit_zero;
        logic idx_ok;
        logic hit;
        logic exhausted;
        logic sweep_last;
    } t_stat;

endpackage

// ----- rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap first-fit block allocator.
//
// A request is taken when i_start is high while o_busy is low, and its result
// appears on o_granted_index and o_status for exactly one cycle with o_valid
// high; results cannot be held off, so capture them when o_valid is seen. An
// allocate or free walks the bitmap memory one word of BUCKET_BITS blocks per
// cycle, from word 0 to the word in which the request ends, with o_busy high
// throughout, and its result shows in the first cycle that o_busy is low
// again. A free ends in the word that holds its block; an allocate ends in
// the word of the first free block or, on a full map, in the word of the last
// managed block. A zero block count, an out-of-range free or an unused mode
// reports in the cycle after the request is taken, without raising o_busy. A
// clear request, and the clearing pass after reset, write one word per cycle
// until every word of the bitmap is zero, and no request is taken meanwhile;
// the result of a clear shows in the first cycle that o_busy is low again. The
// block_count register may be written over APB at any idle time.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS  = bba_pkg::DEF_MAX_BLOCKS,
    parameter int BUCKET_BITS = bba_pkg::DEF_BUCKET_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bba_pkg::MODE_W-1:0]      i_mode,
    input  logic [bba_pkg::IDX_W-1:0]       i_block_index,
    output logic                            o_busy,
    output logic                            o_valid,
    output logic [bba_pkg::IDX_W-1:0]       o_granted_index,
    output logic [bba_pkg::STATUS_W-1:0]    o_status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]     paddr,
    input  logic [bba_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bba_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    bba_pkg::t_cmd               cmd;
    bba_pkg::t_stat              stat;
    logic [bba_pkg::COUNT_W-1:0] block_count;

    bba_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_block_count (block_count)
    );

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    bba_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BUCKET_BITS (BUCKET_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_block_index   (i_block_index),
        .i_block_count   (block_count),
        .o_valid         (o_valid),
        .o_granted_index (o_granted_index),
        .o_status        (o_status)
    );

endmodule

// ----- rtl/bba_regs.sv -----
// APB configuration register holding the managed block count.
module bba_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]       paddr,
    input  logic [bba_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bba_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [bba_pkg::COUNT_W-1:0]       o_block_count
);

    logic [bba_pkg::COUNT_W-1:0] r_block_count;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr == bba_pkg::ADDR_BLOCK_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= bba_pkg::COUNT_RESET;
        end else if (wr_en) begin
            r_block_count <= pwdata[bba_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr == bba_pkg::ADDR_BLOCK_COUNT) begin
            prdata = bba_pkg::APB_DATA_W'(r_block_count);
        end else begin
            prdata = '0;
        end
    end

    assign o_block_count = r_block_count;

endmodule

// ----- rtl/bba_ctrl.sv -----
// Controller state machine sequencing clear sweeps and bitmap scans.
module bba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bba_pkg::MODE_W-1:0]    i_mode,
    input  bba_pkg::t_stat                i_stat,
    output bba_pkg::t_cmd                 o_cmd,
    output logic                          o_busy
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;
    logic            r_alloc;
    logic            n_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_INIT;
            r_alloc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alloc <= n_alloc;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_alloc      = r_alloc;
        o_cmd        = '0;
        o_cmd.status = bba_pkg::ST_OK;
        case (r_state)
            bba_pkg::S_INIT: begin
                o_cmd.sweep_en = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        bba_pkg::MODE_ALLOC: begin
                            n_alloc = 1'b1;
                            if (i_stat.limit_zero) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = bba_pkg::ST_FULL;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = bba_pkg::S_SCAN;
                            end
                        end
                        bba_pkg::MODE_FREE: begin
                            n_alloc = 1'b0;
                            if (!i_stat.idx_ok) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = bba_pkg::ST_RANGE;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = bba_pkg::S_SCAN;
                            end
                        end
                        bba_pkg::MODE_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = bba_pkg::S_CLEAR;
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            bba_pkg::S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.grant  = r_alloc;
                    n_state      = bba_pkg::S_IDLE;
                end else if (i_stat.exhausted) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = bba_pkg::ST_FULL;
                    n_state      = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_CLEAR: begin
                o_cmd.sweep_en = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != bba_pkg::S_IDLE);

endmodule

// ----- rtl/bba_dp.sv -----
// Datapath with the used/free bitmap memory, scan counters and result register.
module bba_dp #(
    parameter int MAX_BLOCKS  = bba_pkg::DEF_MAX_BLOCKS,
    parameter int BUCKET_BITS = bba_pkg::DEF_BUCKET_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bba_pkg::t_cmd                   i_cmd,
    output bba_pkg::t_stat                  o_stat,
    input  logic [bba_pkg::MODE_W-1:0]      i_mode,
    input  logic [bba_pkg::IDX_W-1:0]       i_block_index,
    input  logic [bba_pkg::COUNT_W-1:0]     i_block_count,
    output logic                            o_valid,
    output logic [bba_pkg::IDX_W-1:0]       o_granted_index,
    output logic [bba_pkg::STATUS_W-1:0]    o_status
);

    localparam int DEPTH = (MAX_BLOCKS + BUCKET_BITS - 1) / BUCKET_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACW   = $clog2(DEPTH + 1);
    localparam int CW_A  = $clog2(MAX_BLOCKS + 2 * BUCKET_BITS + 1);
    localparam int CW    = (CW_A > bba_pkg::COUNT_W) ? CW_A : bba_pkg::COUNT_W;
    localparam int BW    = (BUCKET_BITS > 1) ? $clog2(BUCKET_BITS) : 1;

    logic [BUCKET_BITS-1:0]      mem [DEPTH];
    logic [BUCKET_BITS-1:0]      r_rdata;
    logic [ACW-1:0]              r_addr;
    logic [AW-1:0]               r_daddr;
    logic [CW-1:0]               r_abase;
    logic [CW-1:0]               r_dbase;
    logic                        r_dvalid;
    logic                        r_alloc;
    logic [bba_pkg::IDX_W-1:0]   r_idx;

    logic [CW-1:0]               limit;
    logic [CW-1:0]               dend;
    logic [CW-1:0]               idx_ext;
    logic [CW-1:0]               off;
    logic [CW-1:0]               grant_sum;
    logic [BUCKET_BITS-1:0]      cand;
    logic [BUCKET_BITS-1:0]      alloc_word;
    logic [BUCKET_BITS-1:0]      free_word;
    logic [BUCKET_BITS-1:0]      wdata;
    logic [AW-1:0]               waddr;
    logic [BW-1:0]               first_bit;
    logic                        found;
    logic                        in_word;
    logic                        addr_in;
    logic                        we;

    assign addr_in = (r_addr < ACW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_dvalid <= 1'b0;
            r_abase  <= '0;
        end else if (i_cmd.scan_start || i_cmd.sweep_start) begin
            r_addr   <= '0;
            r_dvalid <= 1'b0;
            r_abase  <= '0;
        end else if (i_cmd.sweep_en) begin
            r_addr <= r_addr + ACW'(1);
        end else if (i_cmd.scan_en) begin
            r_dvalid <= addr_in;
            if (addr_in) begin
                r_addr  <= r_addr + ACW'(1);
                r_abase <= r_abase + CW'(BUCKET_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_alloc <= (i_mode == bba_pkg::MODE_ALLOC);
            r_idx   <= i_block_index;
        end
        if (i_cmd.scan_en && addr_in) begin
            r_daddr <= r_addr[AW-1:0];
            r_dbase <= r_abase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.scan_en && addr_in) begin
            r_rdata <= mem[r_addr[AW-1:0]];
        end
    end

    always_comb begin
        limit = (CW'(i_block_count) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                       : CW'(i_block_count);
        dend      = r_dbase + CW'(BUCKET_BITS);
        idx_ext   = CW'(r_idx);
        off       = idx_ext - r_dbase;
        in_word   = (idx_ext < dend);
        found     = 1'b0;
        first_bit = '0;
        for (int b = 0; b < BUCKET_BITS; b++) begin
            cand[b] = !r_rdata[b] && ((r_dbase + CW'(b)) < limit);
        end
        for (int b = 0; b < BUCKET_BITS; b++) begin
            if (cand[b] && !found) begin
                found     = 1'b1;
                first_bit = BW'(b);
            end
        end
        alloc_word = r_rdata | (BUCKET_BITS'(1) << first_bit);
        free_word  = r_rdata & ~(BUCKET_BITS'(1) << off[BW-1:0]);
        grant_sum  = r_dbase + CW'(first_bit);
        we         = i_cmd.sweep_en || i_cmd.commit;
        if (i_cmd.sweep_en) begin
            waddr = r_addr[AW-1:0];
            wdata = '0;
        end else begin
            waddr = r_daddr;
            wdata = r_alloc ? alloc_word : free_word;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.limit_zero = (limit == '0);
        o_stat.idx_ok     = (CW'(i_block_index) < limit);
        o_stat.hit        = r_dvalid && (r_alloc ? found : in_word);
        o_stat.exhausted  = r_dvalid && r_alloc && !found && (dend >= limit);
        o_stat.sweep_last = (r_addr == ACW'(DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_granted_index <= i_cmd.grant ? grant_sum[bba_pkg::IDX_W-1:0] : '0;
            o_status        <= i_cmd.status;
        end
    end

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level checker for the bitmap block allocator and its bind statement.
module bba_props (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_start,
    input logic [bba_pkg::MODE_W-1:0]      i_mode,
    input logic                            o_busy,
    input logic                            o_valid,
    input logic [bba_pkg::IDX_W-1:0]       o_granted_index,
    input logic [bba_pkg::STATUS_W-1:0]    o_status
);

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("block not busy after reset");

    a_fail_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bba_pkg::ST_OK)) |-> (o_granted_index == '0))
        else $error("failed request returned a nonzero index");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == bba_pkg::ST_OK || o_status == bba_pkg::ST_FULL
                     || o_status == bba_pkg::ST_RANGE))
        else $error("illegal status code");

    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode != bba_pkg::MODE_ALLOC
         && i_mode != bba_pkg::MODE_FREE && i_mode != bba_pkg::MODE_CLEAR)
        |=> (o_valid && o_status == bba_pkg::ST_OK && !o_busy))
        else $error("unused mode request not answered at once");

endmodule

bind bitmap_block_allocator bba_props u_bba_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .i_mode          (i_mode),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_granted_index (o_granted_index),
    .o_status        (o_status)
);
